### hw/rtl/sbm_pkg.sv
package sbm_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 64;
  localparam int unsigned DATA_W           = 12;
  localparam int unsigned MAG_W            = 24;
  localparam int unsigned CFG_W            = 24;

  localparam logic [MAG_W-1:0] LOWER_RESET = MAG_W'(0);
  localparam logic [MAG_W-1:0] UPPER_RESET = MAG_W'(8388608);

  typedef enum logic {
    REG_LOWER = 1'b0,
    REG_UPPER = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic [MAG_W-1:0]         mag;
  } elem_t;

  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic [MAG_W-1:0]         mag;
    logic                     eor;
    logic                     empty;
  } res_t;

  // Order: magnitude, then real part, then imaginary part.
  function automatic logic comes_first(elem_t a, elem_t b);
    logic r;
    if (a.mag != b.mag) begin
      r = (a.mag < b.mag);
    end else if (a.re != b.re) begin
      r = (a.re < b.re);
    end else begin
      r = (a.im < b.im);
    end
    return r;
  endfunction

endpackage

### hw/rtl/sbm_in_if.sv
interface sbm_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [sbm_pkg::DATA_W-1:0] real_part;
  logic signed [sbm_pkg::DATA_W-1:0] imag_part;
  logic                             final_item;

  modport source (output valid, output real_part, output imag_part, output final_item,
                  input ready);
  modport sink (input valid, input real_part, input imag_part, input final_item,
                output ready);
endinterface

### hw/rtl/sbm_out_if.sv
interface sbm_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [sbm_pkg::DATA_W-1:0] out_real;
  logic signed [sbm_pkg::DATA_W-1:0] out_imag;
  logic [sbm_pkg::MAG_W-1:0]         out_mag_sq;
  logic                             end_of_run;
  logic                             empty_set;

  modport source (output valid, output out_real, output out_imag, output out_mag_sq,
                  output end_of_run, output empty_set, input ready);
  modport sink (input valid, input out_real, input out_imag, input out_mag_sq,
                input end_of_run, input empty_set, output ready);
endinterface

### hw/rtl/sbm_cell.sv
module sbm_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  sbm_pkg::elem_t left_i,
  input  sbm_pkg::elem_t right_held_i,
  output sbm_pkg::elem_t held_o,
  output sbm_pkg::elem_t pass_o
);

  sbm_pkg::elem_t held_d, held_q, pass_d, pass_q;

  always_comb begin
    held_d     = held_q;
    pass_d     = left_i;
    pass_d.vld = 1'b0;
    if (shift_i) begin
      held_d = right_held_i;
    end else if (left_i.vld) begin
      if (!held_q.vld) begin
        held_d = left_i;
      end else if (sbm_pkg::comes_first(left_i, held_q)) begin
        // keep the smaller one, push the held one along
        held_d = left_i;
        pass_d = held_q;
      end else begin
        pass_d = left_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pass_q <= '0;
    end else begin
      held_q <= held_d;
      pass_q <= pass_d;
    end
  end

  assign held_o = held_q;
  assign pass_o = pass_q;

endmodule

### hw/rtl/sort_by_magnitude_range_select_top.sv
// A set is loaded, then left to settle, then drained, ending with a closing result; the
//   drain waits on output stalls. The settle time covers the depth of the insertion cell
//   chain that the last element may have to cross. Input is taken only while loading, so
//   a new set waits until the previous one has drained and closed.
// Reset (rst_ni, asynchronous, active low): clears element count, state, the chain
//   cells, the pipeline and output registers; bounds return to 0 and 8388608.
module sort_by_magnitude_range_select_top #(
  parameter int unsigned MAX_ELEMENTS = sbm_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  sbm_in_if.sink                    in_i,
  sbm_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [sbm_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int unsigned CntW    = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SetW    = $clog2(MAX_ELEMENTS + 3);
  localparam int unsigned SettleN = MAX_ELEMENTS + 2;

  sbm_pkg::state_e state_d, state_q;
  logic [CntW-1:0] count_d, count_q;
  logic [SetW-1:0] settle_d, settle_q;
  sbm_pkg::elem_t  pend_d, pend_q;
  sbm_pkg::res_t   out_d, out_q;
  sbm_pkg::elem_t  s1_d, s1_q, ent_d, ent_q;
  logic [sbm_pkg::MAG_W-1:0] lower_q, upper_q;

  sbm_pkg::elem_t held [MAX_ELEMENTS];
  sbm_pkg::elem_t pass [MAX_ELEMENTS];

  logic shift;
  logic in_acc;
  logic out_free;
  logic hit;
  logic signed [sbm_pkg::MAG_W-1:0] sq_re, sq_im;

  // Bounds registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= sbm_pkg::LOWER_RESET;
      upper_q <= sbm_pkg::UPPER_RESET;
    end else if (cfg_we_i) begin
      case (sbm_pkg::reg_idx_e'(cfg_idx_i))
        sbm_pkg::REG_LOWER: lower_q <= cfg_data_i;
        sbm_pkg::REG_UPPER: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == sbm_pkg::ST_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;

  // Input stage: capture the element; drop it when the chain is full.
  always_comb begin
    s1_d     = '0;
    s1_d.vld = in_acc && (count_q < CntW'(MAX_ELEMENTS));
    s1_d.re  = in_i.real_part;
    s1_d.im  = in_i.imag_part;
  end

  // Square stage: form the squared magnitude before the chain.
  assign sq_re = s1_q.re * s1_q.re;
  assign sq_im = s1_q.im * s1_q.im;

  always_comb begin
    ent_d     = s1_q;
    ent_d.mag = sbm_pkg::MAG_W'($unsigned(sq_re) + $unsigned(sq_im));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      ent_q <= '0;
    end else begin
      s1_q  <= s1_d;
      ent_q <= ent_d;
    end
  end

  // Insertion chain: cell 0 holds the smallest element; drain shifts toward cell 0.
  for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
    sbm_pkg::elem_t left, right;
    if (g == 0) begin : g_first
      assign left = ent_q;
    end else begin : g_mid
      assign left = pass[g-1];
    end
    if (g == MAX_ELEMENTS - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = held[g+1];
    end
    sbm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (shift),
      .left_i       (left),
      .right_held_i (right),
      .held_o       (held[g]),
      .pass_o       (pass[g])
    );
  end

  // Range test on the head of the chain
  assign hit = (lower_q < upper_q) && (held[0].mag >= lower_q) && (held[0].mag < upper_q);

  assign out_free = !out_q.vld || out_o.ready;

  // Control: load, let the last element settle, then drain through a one-deep
  // pending slot so the final hit can be flagged end of run.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    settle_d = settle_q;
    pend_d   = pend_q;
    out_d    = out_q;
    shift    = 1'b0;
    if (out_free) begin
      out_d.vld = 1'b0;
    end
    case (state_q)
      sbm_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (count_q < CntW'(MAX_ELEMENTS)) begin
            count_d = count_q + CntW'(1);
          end
          if (in_i.final_item) begin
            state_d  = sbm_pkg::ST_SETTLE;
            settle_d = SetW'(SettleN);
          end
        end
      end
      sbm_pkg::ST_SETTLE: begin
        if (settle_q == '0) begin
          state_d = sbm_pkg::ST_DRAIN;
        end else begin
          settle_d = settle_q - SetW'(1);
        end
      end
      sbm_pkg::ST_DRAIN: begin
        if (count_q != '0) begin
          if (!hit) begin
            shift   = 1'b1;
            count_d = count_q - CntW'(1);
          end else if (!pend_q.vld) begin
            pend_d  = held[0];
            shift   = 1'b1;
            count_d = count_q - CntW'(1);
          end else if (out_free) begin
            out_d.vld   = 1'b1;
            out_d.re    = pend_q.re;
            out_d.im    = pend_q.im;
            out_d.mag   = pend_q.mag;
            out_d.eor   = 1'b0;
            out_d.empty = 1'b0;
            pend_d      = held[0];
            shift       = 1'b1;
            count_d     = count_q - CntW'(1);
          end
        end else if (out_free) begin
          out_d.vld = 1'b1;
          out_d.eor = 1'b1;
          if (pend_q.vld) begin
            out_d.re    = pend_q.re;
            out_d.im    = pend_q.im;
            out_d.mag   = pend_q.mag;
            out_d.empty = 1'b0;
          end else begin
            out_d.re    = '0;
            out_d.im    = '0;
            out_d.mag   = '0;
            out_d.empty = 1'b1;
          end
          pend_d.vld = 1'b0;
          state_d    = sbm_pkg::ST_LOAD;
        end
      end
      default: state_d = sbm_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sbm_pkg::ST_LOAD;
      count_q  <= '0;
      settle_q <= '0;
      pend_q   <= '0;
      out_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      settle_q <= settle_d;
      pend_q   <= pend_d;
      out_q    <= out_d;
    end
  end

  assign out_o.valid      = out_q.vld;
  assign out_o.out_real   = out_q.re;
  assign out_o.out_imag   = out_q.im;
  assign out_o.out_mag_sq = out_q.mag;
  assign out_o.end_of_run = out_q.eor;
  assign out_o.empty_set  = out_q.empty;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ELEMENTS))
    else $error("element count above chain depth");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbm_pkg::ST_DRAIN) && (count_q != '0) |-> held[0].vld)
    else $error("chain head empty while elements remain");

  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbm_pkg::ST_LOAD) |-> !pend_q.vld)
    else $error("pending element left over while loading");

  a_empty_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_q.vld && out_q.empty |-> out_q.eor && (out_q.mag == '0))
    else $error("empty result without end of run");

  a_chain_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbm_pkg::ST_DRAIN) |-> !ent_q.vld && !s1_q.vld)
    else $error("element in flight during drain");
`endif

endmodule

### test/sbm_range_checker.sv
`timescale 1ns / 100ps
module sbm_range_checker #(
  parameter int unsigned MAX_ELEMENTS = sbm_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  sbm_in_if                         in_ch,
  sbm_out_if                        out_ch,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [sbm_pkg::CFG_W-1:0] cfg_data_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o
);

  typedef struct packed {
    logic signed [sbm_pkg::DATA_W-1:0] re;
    logic signed [sbm_pkg::DATA_W-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic signed [sbm_pkg::DATA_W-1:0] re;
    logic signed [sbm_pkg::DATA_W-1:0] im;
    logic [sbm_pkg::MAG_W-1:0]         mag;
    logic                              eor;
    logic                              empty;
  } pick_t;

  cplx_t                     loaded [MAX_ELEMENTS];
  int unsigned               loaded_len;
  logic [sbm_pkg::MAG_W-1:0] lower_sq;
  logic [sbm_pkg::MAG_W-1:0] upper_sq;
  pick_t                     picks_q [$];
  int unsigned               mismatches = 0;

  function automatic logic [sbm_pkg::MAG_W-1:0] mag_of(cplx_t e);
    int r;
    int i;
    r = $signed(e.re);
    i = $signed(e.im);
    return sbm_pkg::MAG_W'(r * r + i * i);
  endfunction

  // Magnitude first, then real part, then imaginary part.
  function automatic bit ranks_ahead(cplx_t a, cplx_t b);
    logic [sbm_pkg::MAG_W-1:0] ma;
    logic [sbm_pkg::MAG_W-1:0] mb;
    ma = mag_of(a);
    mb = mag_of(b);
    if (ma != mb) return ma < mb;
    if (a.re != b.re) return $signed(a.re) < $signed(b.re);
    return $signed(a.im) < $signed(b.im);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: range select mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Sort the loaded set and queue every element that falls in [lower, upper).
  task automatic close_set();
    cplx_t v;
    int    j;
    pick_t p;
    int    hits;
    for (int i = 1; i < int'(loaded_len); i++) begin
      v = loaded[i];
      j = i;
      while (j > 0 && ranks_ahead(v, loaded[j-1])) begin
        loaded[j] = loaded[j-1];
        j--;
      end
      loaded[j] = v;
    end
    hits = 0;
    if (lower_sq < upper_sq) begin
      for (int i = 0; i < int'(loaded_len); i++) begin
        p.mag = mag_of(loaded[i]);
        if (p.mag >= lower_sq && p.mag < upper_sq) begin
          p.re    = loaded[i].re;
          p.im    = loaded[i].im;
          p.eor   = 1'b0;
          p.empty = 1'b0;
          picks_q.insert(picks_q.size(), p);
          hits++;
        end
      end
    end
    if (hits == 0) begin
      p.re    = '0;
      p.im    = '0;
      p.mag   = '0;
      p.eor   = 1'b1;
      p.empty = 1'b1;
      picks_q.insert(picks_q.size(), p);
    end else begin
      p = picks_q.pop_back();
      p.eor = 1'b1;
      picks_q.insert(picks_q.size(), p);
    end
    loaded_len = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pick_t want;
    if (!rst_ni) begin
      loaded_len = 0;
      picks_q.delete();
      lower_sq   = sbm_pkg::LOWER_RESET;
      upper_sq   = sbm_pkg::UPPER_RESET;
    end else begin
      if (cfg_we_i) begin
        case (sbm_pkg::reg_idx_e'(cfg_idx_i))
          sbm_pkg::REG_LOWER: lower_sq = cfg_data_i[sbm_pkg::MAG_W-1:0];
          sbm_pkg::REG_UPPER: upper_sq = cfg_data_i[sbm_pkg::MAG_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        // Drop elements beyond the store depth; a final flag still closes the set.
        if (loaded_len < MAX_ELEMENTS) begin
          loaded[loaded_len] = '{re: in_ch.real_part, im: in_ch.imag_part};
          loaded_len++;
        end
        if (in_ch.final_item) close_set();
      end
      if (out_ch.valid && out_ch.ready) begin
        if (picks_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item re %0d im %0d mag %0d",
                                    out_ch.out_real, out_ch.out_imag, out_ch.out_mag_sq));
        end else begin
          want = picks_q.pop_front();
          if (out_ch.out_real !== want.re)
            report_mismatch($sformatf("out_real %0d, want %0d", out_ch.out_real, want.re));
          if (out_ch.out_imag !== want.im)
            report_mismatch($sformatf("out_imag %0d, want %0d", out_ch.out_imag, want.im));
          if (out_ch.out_mag_sq !== want.mag)
            report_mismatch($sformatf("out_mag_sq %0d, want %0d", out_ch.out_mag_sq,
                                      want.mag));
          if (out_ch.end_of_run !== want.eor)
            report_mismatch($sformatf("end_of_run %b, want %b", out_ch.end_of_run, want.eor));
          if (out_ch.empty_set !== want.empty)
            report_mismatch($sformatf("empty_set %b, want %b", out_ch.empty_set, want.empty));
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= picks_q.size();
  end

endmodule

### test/sort_by_magnitude_range_select_top_tb.sv
`timescale 1ns / 100ps
module sort_by_magnitude_range_select_top_tb;

  localparam int unsigned MAX_ELEMENTS = sbm_pkg::MAX_ELEMENTS_DEF;
  // Generous ceiling on the run length, well above what the slow sets need.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Receiver hold-off long enough for a full set to load, settle and back up.
  localparam int unsigned LONG_HOLD    = 400;
  // Quiet time after the last result before touching the bounds.
  localparam int unsigned SETTLE_GAP   = MAX_ELEMENTS + 16;

  logic                      clk_i      = 1'b0;
  logic                      rst_ni     = 1'b0;
  logic                      cfg_we_i   = 1'b0;
  logic                      cfg_idx_i  = sbm_pkg::REG_LOWER;
  logic [sbm_pkg::CFG_W-1:0] cfg_data_i = '0;

  sbm_in_if  in_ch ();
  sbm_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent    = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_req      = 1'b0;

  sort_by_magnitude_range_select_top #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  sbm_range_checker #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #1 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: stall at the current rate; a toggle of hold_req starts a long
  // hold-off, counted down here so the sender keeps running meanwhile.
  initial begin
    logic        hold_seen;
    int unsigned hold_left;
    hold_seen    = 1'b0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic signed [sbm_pkg::DATA_W-1:0] corner_value();
    case ($urandom_range(4))
      0: return -12'sd2048;
      1: return 12'sd2047;
      2: return 12'sd0;
      3: return -12'sd1;
      default: return 12'sd1;
    endcase
  endfunction

  // Mix full-range values, tiny values, corners and the magnitude-25 lattice
  // points so that ties on magnitude and on real part come up often.
  task automatic draw_element(output logic signed [sbm_pkg::DATA_W-1:0] re,
                              output logic signed [sbm_pkg::DATA_W-1:0] im);
    case ($urandom_range(3))
      0: begin
        re = sbm_pkg::DATA_W'($urandom);
        im = sbm_pkg::DATA_W'($urandom);
      end
      1: begin
        re = sbm_pkg::DATA_W'(int'($urandom_range(12)) - 6);
        im = sbm_pkg::DATA_W'(int'($urandom_range(12)) - 6);
      end
      2: begin
        re = corner_value();
        im = corner_value();
      end
      default: begin
        case ($urandom_range(3))
          0: begin re = 12'sd3; im = 12'sd4; end
          1: begin re = 12'sd4; im = 12'sd3; end
          2: begin re = 12'sd5; im = 12'sd0; end
          default: begin re = 12'sd0; im = 12'sd5; end
        endcase
        if ($urandom_range(1)) re = -re;
        if ($urandom_range(1)) im = -im;
      end
    endcase
  endtask

  // Offer one item and hold it until accepted. Valid stays high on return so
  // a back-to-back item needs no second assignment in the same step.
  task automatic offer_element(input logic signed [sbm_pkg::DATA_W-1:0] re,
                               input logic signed [sbm_pkg::DATA_W-1:0] im,
                               input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.real_part  <= re;
    in_ch.imag_part  <= im;
    in_ch.final_item <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_set(input int unsigned n);
    logic signed [sbm_pkg::DATA_W-1:0] re;
    logic signed [sbm_pkg::DATA_W-1:0] im;
    for (int unsigned k = 0; k < n; k++) begin
      draw_element(re, im);
      offer_element(re, im, k == n - 1);
    end
  endtask

  // Mostly small sets; now and then a large one or one that overflows the store.
  task automatic random_sets(input int unsigned budget);
    int unsigned start;
    int unsigned r;
    int unsigned n;
    start = items_sent;
    while (items_sent - start < budget) begin
      r = $urandom_range(99);
      if (r < 70)      n = $urandom_range(8, 1);
      else if (r < 92) n = $urandom_range(32, 9);
      else if (r < 97) n = $urandom_range(MAX_ELEMENTS, 33);
      else             n = $urandom_range(MAX_ELEMENTS + 6, MAX_ELEMENTS + 1);
      send_set(n);
    end
  endtask

  // Drop valid, wait out every expected result, then let the block go idle.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_GAP) @(posedge clk_i);
  endtask

  task automatic set_bounds(input logic [sbm_pkg::CFG_W-1:0] lo,
                            input logic [sbm_pkg::CFG_W-1:0] hi);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sbm_pkg::REG_LOWER;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i  <= sbm_pkg::REG_UPPER;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_phase(input logic [sbm_pkg::CFG_W-1:0] lo,
                           input logic [sbm_pkg::CFG_W-1:0] hi,
                           input int unsigned idle, input int unsigned stall,
                           input int unsigned budget);
    set_bounds(lo, hi);
    send_idle_pct = idle;
    stall_pct     = stall;
    random_sets(budget);
    quiesce();
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.real_part  = '0;
    in_ch.imag_part  = '0;
    in_ch.final_item = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets under the reset bounds, no idling. The corner at
    // (-2048,-2048) sits exactly on the exclusive upper bound and must drop out;
    // the magnitude-25 group checks the real and imaginary tie-breaks, with a
    // full duplicate among them.
    offer_element(-12'sd2048, -12'sd2048, 1'b0);
    offer_element(12'sd2047, 12'sd2047, 1'b0);
    offer_element(12'sd0, 12'sd0, 1'b0);
    offer_element(-12'sd2048, 12'sd0, 1'b0);
    offer_element(12'sd0, -12'sd2048, 1'b0);
    offer_element(12'sd2047, -12'sd2048, 1'b0);
    offer_element(-12'sd2048, 12'sd2047, 1'b0);
    offer_element(12'sd3, 12'sd4, 1'b0);
    offer_element(12'sd4, 12'sd3, 1'b0);
    offer_element(-12'sd3, 12'sd4, 1'b0);
    offer_element(12'sd3, -12'sd4, 1'b0);
    offer_element(-12'sd4, -12'sd3, 1'b0);
    offer_element(12'sd5, 12'sd0, 1'b0);
    offer_element(12'sd0, -12'sd5, 1'b0);
    offer_element(12'sd3, 12'sd4, 1'b0);
    offer_element(-12'sd1, -12'sd1, 1'b1);
    // Single-element set.
    offer_element(12'sd7, -12'sd9, 1'b1);
    // Nothing in range: expect the empty item.
    offer_element(-12'sd2048, -12'sd2048, 1'b1);
    random_sets(12);
    quiesce();

    // Mid-range window, sender idling.
    run_phase(24'd25, 24'd1000000, 86, 0, 30);
    // Inverted bounds at the register extremes: every set yields the empty item.
    run_phase(24'hFFFFFF, 24'd0, 0, 86, 25);
    // Lower bound at the top of the magnitude range; only the largest corner qualifies.
    run_phase(24'd8388608, 24'hFFFFFF, 26, 26, 25);
    // Equal bounds: empty window.
    run_phase(24'd300, 24'd300, 26, 86, 15);

    // Pressure: hold the receiver off while full and overflowing sets keep
    // coming, so the block backs up and stalls its input.
    set_bounds(24'd100, 24'd3000000);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = ~hold_req;
    send_set(MAX_ELEMENTS);
    send_set(MAX_ELEMENTS + 6);
    send_set(20);
    stall_pct = 26;
    random_sets(15);
    quiesce();

    // Back to the reset bounds, full speed.
    run_phase(24'd0, 24'd8388608, 0, 0, 20);

    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/sbm_pkg.sv
hw/rtl/sbm_in_if.sv
hw/rtl/sbm_out_if.sv
hw/rtl/sbm_cell.sv
hw/rtl/sort_by_magnitude_range_select_top.sv
test/sbm_range_checker.sv
test/sort_by_magnitude_range_select_top_tb.sv
